// ===== rtl/core/iterated_sha256_hasher_core_assert.svh =====
// ----------------------------------------------------------------------------
// Iterated SHA-256 hasher assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// The macros expect signals named clock and reset in the calling scope.
// ----------------------------------------------------------------------------
`ifndef ITERATED_SHA256_HASHER_CORE_ASSERT_SVH
`define ITERATED_SHA256_HASHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ISH_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ish assertion failed");
// next-cycle implication
`define ISH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ish assertion failed");
`else
`define ISH_ASSERT_SAME(lbl, ante, cons)
`define ISH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/ish_pkg.sv =====
// ----------------------------------------------------------------------------
// Iterated SHA-256 hasher package
// Payload types, SHA-256 constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ish_pkg;

   localparam int PASS_COUNT_BITS_DEF = 16;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_A     = 8'd97;

   typedef logic [7:0][31:0] ish_words_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_byte;
   } ish_req_type;

   typedef struct packed {
      logic [31:0] digest_word_0;
      logic [31:0] digest_word_1;
      logic [31:0] digest_word_2;
      logic [31:0] digest_word_3;
      logic [31:0] digest_word_4;
      logic [31:0] digest_word_5;
      logic [31:0] digest_word_6;
      logic [31:0] digest_word_7;
   } ish_rsp_type;

   localparam ish_words_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   // lowercase hex character of one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] n8;
      n8 = {4'd0, nib};
      if (nib < 4'd10) return ASCII_ZERO + n8;
      else return ASCII_A - 8'd10 + n8;
   endfunction

   // round constants
   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ish_round.sv =====
// ----------------------------------------------------------------------------
// Iterated SHA-256 hasher round unit
// One SHA-256 round with its message schedule step, shared by all 64 rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module ish_round (
   input  wire ish_pkg::ish_words_type vars_cur,
   input  wire logic [31:0]            w_tap0,
   input  wire logic [31:0]            w_tap1,
   input  wire logic [31:0]            w_tap9,
   input  wire logic [31:0]            w_tap14,
   input  wire logic                   use_msg,
   input  wire logic [31:0]            k_word,
   output ish_pkg::ish_words_type      vars_nxt,
   output logic [31:0]                 w_word
);
   import ish_pkg::*;

   logic [31:0] sig0, sig1, sum0, sum1, ch, maj, t1, t2;

   // message schedule: buffer word for the first 16 rounds, expansion after
   assign sig0 = {w_tap1[6:0], w_tap1[31:7]} ^ {w_tap1[17:0], w_tap1[31:18]} ^
                 (w_tap1 >> 3);
   assign sig1 = {w_tap14[16:0], w_tap14[31:17]} ^ {w_tap14[18:0], w_tap14[31:19]} ^
                 (w_tap14 >> 10);
   assign w_word = use_msg ? w_tap0 : (w_tap0 + sig0 + w_tap9 + sig1);

   // compression round
   assign sum1 = {vars_cur[4][5:0], vars_cur[4][31:6]} ^
                 {vars_cur[4][10:0], vars_cur[4][31:11]} ^
                 {vars_cur[4][24:0], vars_cur[4][31:25]};
   assign ch   = vars_cur[6] ^ (vars_cur[4] & (vars_cur[5] ^ vars_cur[6]));
   assign sum0 = {vars_cur[0][1:0], vars_cur[0][31:2]} ^
                 {vars_cur[0][12:0], vars_cur[0][31:13]} ^
                 {vars_cur[0][21:0], vars_cur[0][31:22]};
   assign maj  = (vars_cur[0] & vars_cur[1]) | (vars_cur[2] & (vars_cur[0] | vars_cur[1]));
   assign t1   = vars_cur[7] + sum1 + ch + k_word + w_word;
   assign t2   = sum0 + maj;

   always_comb begin
      vars_nxt[7] = vars_cur[6];
      vars_nxt[6] = vars_cur[5];
      vars_nxt[5] = vars_cur[4];
      vars_nxt[4] = vars_cur[3] + t1;
      vars_nxt[3] = vars_cur[2];
      vars_nxt[2] = vars_cur[1];
      vars_nxt[1] = vars_cur[0];
      vars_nxt[0] = t1 + t2;
   end

endmodule

`default_nettype wire

// ===== rtl/core/iterated_sha256_hasher_core.sv =====
// ----------------------------------------------------------------------------
// Iterated SHA-256 hasher core
// SHA-256 of a byte stream, optionally rehashed as hex text several times.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one request per message byte (data_byte, has_byte) with
//    last_byte on the final request; a last request with has_byte low
//    closes the message without adding a byte (empty message allowed).
//  - csr channel: writes iteration_count (total passes, 0 acts as 1);
//    always ready, write only while the core is idle.
//  - rsp channel: one result per message, the eight digest words.
// Operation:
//  - a plain byte is accepted whenever the core is idle; every 64th byte adds a
//    block compression (load, 64 rounds on the one shared round unit, add).
//  - after the last request: padding writes one byte a cycle, pausing while
//    a filled block compresses (one or two compressions); each further pass
//    costs 64 hex bytes plus two compressions.
//  - reset returns to the initial hash, iteration_count to 1.
//  - the result sits in an output register; the core takes new bytes while
//    it waits, and only stalls a later message end until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module iterated_sha256_hasher_core #(
   parameter int PASS_COUNT_BITS = ish_pkg::PASS_COUNT_BITS_DEF
) (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   input  wire  logic                 req_valid,
   output logic                       req_ready,
   input  wire  ish_pkg::ish_req_type req_data,
   output logic                       rsp_valid,
   input  wire  logic                 rsp_ready,
   output ish_pkg::ish_rsp_type       rsp_data,
   input  wire  logic                 csr_valid,
   output logic                       csr_ready,
   input  wire  logic [15:0]          csr_data
);
   import ish_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PAD80 = 4'd1;
   localparam logic [3:0] S_ZERO  = 4'd2;
   localparam logic [3:0] S_LEN   = 4'd3;
   localparam logic [3:0] S_CLOAD = 4'd4;
   localparam logic [3:0] S_ROUND = 4'd5;
   localparam logic [3:0] S_CADD  = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;
   localparam logic [3:0] S_HEX   = 4'd8;

   logic [3:0]                 state_ff, state_in, ret_ff, ret_in;
   logic [5:0]                 pos_ff, pos_in, round_ff, round_in;
   logic [63:0]                len_ff, len_in;
   logic [PASS_COUNT_BITS-1:0] pass_ff, pass_in;
   logic [15:0]                iter_ff;
   ish_words_type              hash_ff, hash_in, wv_ff, wv_in, wv_rnd;
   logic [15:0][31:0]          w_ff, w_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ish_rsp_type                rsp_ff, rsp_in;
   logic                       wr_en;
   logic [7:0]                 wr_byte;
   logic [31:0]                w_new;
   logic                       last_pos;

   // shared round unit
   ish_round u_round (
      .vars_cur (wv_ff),
      .w_tap0   (w_ff[0]),
      .w_tap1   (w_ff[1]),
      .w_tap9   (w_ff[9]),
      .w_tap14  (w_ff[14]),
      .use_msg  (round_ff < 6'd16),
      .k_word   (round_k(round_ff)),
      .vars_nxt (wv_rnd),
      .w_word   (w_new)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign last_pos  = (pos_ff == 6'd63);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      pos_in       = pos_ff;
      round_in     = round_ff;
      len_in       = len_ff;
      pass_in      = pass_ff;
      hash_in      = hash_ff;
      wv_in        = wv_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_byte      = 8'd0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.last_byte) pass_in = PASS_COUNT_BITS'(iter_ff);
               if (req_data.has_byte) begin
                  wr_en   = 1'b1;
                  wr_byte = req_data.data_byte;
                  pos_in  = pos_ff + 6'd1;
                  len_in  = len_ff + 64'd8;
               end
               if (req_data.has_byte && last_pos) begin
                  state_in = S_CLOAD;
                  ret_in   = req_data.last_byte ? S_PAD80 : S_IDLE;
               end else if (req_data.last_byte) begin
                  state_in = S_PAD80;
               end
            end
         end
         S_PAD80, S_ZERO: begin
            wr_en   = 1'b1;
            wr_byte = (state_ff == S_PAD80) ? PAD_BYTE : 8'd0;
            pos_in  = pos_ff + 6'd1;
            if (last_pos) begin
               state_in = S_CLOAD;
               ret_in   = S_ZERO;
            end else if (pos_ff == 6'd55) begin
               state_in = S_LEN;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_LEN: begin
            wr_en   = 1'b1;
            wr_byte = len_ff[{~pos_ff[2:0], 3'b000} +: 8];
            pos_in  = pos_ff + 6'd1;
            if (last_pos) begin
               state_in = S_CLOAD;
               ret_in   = S_DONE;
            end
         end
         S_CLOAD: begin
            wv_in    = hash_ff;
            round_in = 6'd0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            wv_in    = wv_rnd;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = S_CADD;
         end
         S_CADD: begin
            for (int i = 0; i < 8; i++) hash_in[i] = hash_ff[i] + wv_ff[i];
            state_in = ret_ff;
         end
         S_DONE: begin
            if (pass_ff > PASS_COUNT_BITS'(1)) begin
               pass_in  = pass_ff - PASS_COUNT_BITS'(1);
               len_in   = 64'd0;
               state_in = S_HEX;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.digest_word_0 = hash_ff[0];
               rsp_in.digest_word_1 = hash_ff[1];
               rsp_in.digest_word_2 = hash_ff[2];
               rsp_in.digest_word_3 = hash_ff[3];
               rsp_in.digest_word_4 = hash_ff[4];
               rsp_in.digest_word_5 = hash_ff[5];
               rsp_in.digest_word_6 = hash_ff[6];
               rsp_in.digest_word_7 = hash_ff[7];
               rsp_valid_in = 1'b1;
               hash_in      = INIT_HASH;
               len_in       = 64'd0;
               pos_in       = 6'd0;
               pass_in      = '0;
               state_in     = S_IDLE;
            end
         end
         S_HEX: begin
            wr_en   = 1'b1;
            wr_byte = hex_char(hash_ff[pos_ff[5:3]][{~pos_ff[2:0], 2'b00} +: 4]);
            pos_in  = pos_ff + 6'd1;
            len_in  = len_ff + 64'd8;
            if (last_pos) begin
               hash_in  = INIT_HASH;
               state_in = S_CLOAD;
               ret_in   = S_PAD80;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // block buffer and schedule window share one shift line
   always_comb begin
      w_in = w_ff;
      if (state_ff == S_ROUND) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = w_new;
      end
      if (wr_en) w_in[pos_ff[5:2]][{~pos_ff[1:0], 3'b000} +: 8] = wr_byte;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         pos_ff       <= 6'd0;
         round_ff     <= 6'd0;
         len_ff       <= 64'd0;
         pass_ff      <= '0;
         hash_ff      <= INIT_HASH;
         wv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= 16'd1;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         pos_ff       <= pos_in;
         round_ff     <= round_in;
         len_ff       <= len_in;
         pass_ff      <= pass_in;
         hash_ff      <= hash_in;
         wv_ff        <= wv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) iter_ff <= csr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      rsp_ff <= rsp_in;
   end

`include "iterated_sha256_hasher_core_assert.svh"

   `ISH_ASSERT_NEXT(a_rounds_end, (state_ff == S_ROUND) && (round_ff == 6'd63), state_ff == S_CADD)
   `ISH_ASSERT_NEXT(a_load_round0, state_ff == S_CLOAD, (state_ff == S_ROUND) && (round_ff == 6'd0))
   `ISH_ASSERT_SAME(a_hex_aligned, (state_ff == S_HEX) && (pos_ff == 6'd0), len_ff == 64'd0)

endmodule

`default_nettype wire

// ===== sim/tb_iterated_sha256_hasher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterated SHA-256 hasher core testbench
// Streams messages into the core one byte per request under several pass
// counts, predicts each digest with its own SHA-256 model and checks every
// result word by word. The request and result channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_iterated_sha256_hasher_core;
   import ish_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 20000000;
   localparam int unsigned ITEM_TARGET = 1950;
   localparam int unsigned SETTLE_CYCLES = 300;

   localparam bit [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam bit [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic bit [31:0] ror32(input bit [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // digest prediction and result checking
   class digest_tracker;
      bit [31:0]   chain [8];
      bit [7:0]    blk [64];
      int unsigned fill;
      bit [63:0]   msg_bits;
      bit [15:0]   pass_total;
      ish_rsp_type digests_due [$];
      int unsigned errors;

      function new();
         pass_total = 16'd1;
         errors = 0;
         restart();
      endfunction

      function void restart();
         chain = START_HASH;
         fill = 0;
         msg_bits = '0;
      endfunction

      function void compress();
         bit [31:0] w [64];
         bit [31:0] v [8];
         bit [31:0] s0, s1, t1, t2;
         for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
         for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
         v = chain;
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++)
            chain[i] += v[i];
      endfunction

      function void absorb(input bit [7:0] b);
         blk[fill] = b;
         msg_bits += 64'd8;
         fill = (fill + 1) % 64;
         if (fill == 0) compress();
      endfunction

      // 0x80, zero fill and 64-bit length, one or two blocks
      function void close_message();
         blk[fill] = PAD_BYTE;
         fill = (fill + 1) % 64;
         if (fill == 0 || fill > 56) begin
            while (fill != 0) begin
               blk[fill] = 8'h00;
               fill = (fill + 1) % 64;
            end
            compress();
         end
         while (fill < 56) begin
            blk[fill] = 8'h00;
            fill++;
         end
         for (int i = 0; i < 8; i++)
            blk[56+i] = msg_bits[63-8*i -: 8];
         fill = 0;
         compress();
      endfunction

      function void note_request(input ish_req_type r);
         bit [31:0]   text [8];
         bit [3:0]    nib;
         int unsigned rounds;
         ish_rsp_type d;
         if (r.has_byte) absorb(r.data_byte);
         if (!r.last_byte) return;
         close_message();
         rounds = (pass_total == 16'd0) ? 1 : pass_total;
         // rehash the lowercase hex text of the digest
         for (int p = 1; p < rounds; p++) begin
            text = chain;
            restart();
            for (int i = 0; i < 8; i++)
               for (int j = 0; j < 8; j++) begin
                  nib = text[i][31-4*j -: 4];
                  absorb(nib < 4'd10 ? 8'd48 + nib : 8'd87 + nib);
               end
            close_message();
         end
         d = {chain[0], chain[1], chain[2], chain[3],
              chain[4], chain[5], chain[6], chain[7]};
         digests_due.push_back(d);
         restart();
      endfunction

      function void check_digest(input ish_rsp_type got);
         ish_rsp_type want;
         if (digests_due.size() == 0) begin
            $display("%0t: unexpected digest %h", $time, got);
            errors++;
            return;
         end
         want = digests_due.pop_front();
         for (int i = 0; i < 8; i++)
            if (want[255-32*i -: 32] !== got[255-32*i -: 32]) begin
               $display("%0t: digest word %0d expected %h actual %h",
                        $time, i, want[255-32*i -: 32], got[255-32*i -: 32]);
               errors++;
            end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   ish_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   ish_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   digest_tracker tracker = new();
   int unsigned   max_gap = 12;
   int unsigned   items_sent = 0;
   int unsigned   cycles = 0;

   iterated_sha256_hasher_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_iterated_sha256_hasher_core: errors");
         $finish;
      end
   end

   function automatic int unsigned draw_gap();
      if (max_gap == 0 || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, max_gap);
   endfunction

   // one request, valid held until accepted
   task automatic send_request(input bit [7:0] b, input bit has, input bit last);
      int unsigned gap;
      ish_req_type r;
      gap = draw_gap();
      r.data_byte = b;
      r.has_byte = has;
      r.last_byte = last;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(r);
      if (has || last) items_sent++;
   endtask

   task automatic drop_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic write_passes(input bit [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.pass_total = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every expected digest is in, then let the core settle
   task automatic wait_drained();
      drop_request();
      while (tracker.digests_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // message of random bytes, with occasional empty requests in between
   task automatic send_message(input int unsigned len);
      bit tail_byte;
      tail_byte = (len > 0) && $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
         send_request(8'($urandom), 1'b1, tail_byte && (i == len - 1));
      end
      if (!tail_byte) send_request(8'($urandom), 1'b0, 1'b1);
   endtask

   function automatic int unsigned draw_length();
      case ($urandom_range(0, 5))
         0: return 55 + $urandom_range(0, 2);
         1: return 63 + $urandom_range(0, 2);
         2: return 119 + $urandom_range(0, 9);
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   // result side
   initial begin
      int unsigned gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_digest(rsp_data);
      end
   end

   // stimulus
   initial begin
      bit [15:0] pass_choices [7];
      int unsigned phase;
      pass_choices = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd4, 16'd1};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset pass count, empty message, extreme bytes, idle request
      max_gap = 0;
      send_request(8'hff, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);
      send_request(8'h5a, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      wait_drained();
      write_passes(16'd0);
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h63, 1'b1, 1'b1);
      wait_drained();
      write_passes(16'd2);
      send_request(8'h00, 1'b0, 1'b1);
      wait_drained();
      // full-scale count is only held mid-message; the value at the end counts
      write_passes(16'hffff);
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h7f, 1'b1, 1'b0);
      wait_drained();
      write_passes(16'd3);
      send_request(8'h01, 1'b1, 1'b1);
      wait_drained();

      // random phases, each ending drained before the next count
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         write_passes(pass_choices[phase % 7] == 16'd4 ?
                      16'($urandom_range(4, 6)) : pass_choices[phase % 7]);
         max_gap = (phase % 3 == 1) ? 0 : 12;
         repeat (20) begin
            if (items_sent < ITEM_TARGET) send_message(draw_length());
         end
         wait_drained();
         phase++;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.digests_due.size() == 0)
         $display("tb_iterated_sha256_hasher_core: clean");
      else
         $display("tb_iterated_sha256_hasher_core: errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ish_pkg.sv
rtl/core/ish_round.sv
rtl/core/iterated_sha256_hasher_core.sv
sim/tb_iterated_sha256_hasher_core.sv
